/* sv/gcd3_pkg.sv */
// gcd3_pkg: shared types, constants and microcode for the three-method gcd unit
`default_nettype none
package gcd3_pkg;

  localparam int DEFAULT_WIDTH = 32;
  localparam int FIELD_W       = 32;
  localparam int METHOD_W      = 2;
  localparam int UPC_W         = 6;

  localparam logic [METHOD_W-1:0] METHOD_SUB   = 2'd0;
  localparam logic [METHOD_W-1:0] METHOD_EUC   = 2'd1;
  localparam logic [METHOD_W-1:0] METHOD_BIN   = 2'd2;
  localparam logic [METHOD_W-1:0] METHOD_RESET = METHOD_EUC;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_DIV_AB,
    OP_DIV_BA,
    OP_DIV_STEP,
    OP_EUC_SHIFT,
    OP_SUB_A,
    OP_SUB_B,
    OP_HALVE_BOTH,
    OP_HALVE_A,
    OP_HALVE_B,
    OP_DIFF_A,
    OP_DIFF_B,
    OP_RET_A,
    OP_RET_B,
    OP_RET_ZERO,
    OP_RET_SHL
  } op_t;

  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_M0,
    C_M1,
    C_M2,
    C_A_ZERO,
    C_B_ZERO,
    C_A_EQ_B,
    C_A_GT_B,
    C_ANY_ODD,
    C_A_EVEN,
    C_B_EVEN,
    C_CNT_NZ
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [UPC_W-1:0] target;
  } cw_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic [METHOD_W-1:0] method;
    logic                a_zero;
    logic                b_zero;
    logic                a_eq_b;
    logic                a_gt_b;
    logic                any_odd;
    logic                a_even;
    logic                b_even;
    logic                cnt_nz;
  } flags_t;

  // sequencer to datapath
  typedef struct packed {
    logic exec;
    op_t  op;
  } ctl_t;

  // program entry points
  localparam logic [UPC_W-1:0] L_EUC      = 6'd4;
  localparam logic [UPC_W-1:0] L_RET_A    = 6'd8;
  localparam logic [UPC_W-1:0] L_SUB      = 6'd9;
  localparam logic [UPC_W-1:0] L_SUB_LOOP = 6'd11;
  localparam logic [UPC_W-1:0] L_SUB_BA   = 6'd13;
  localparam logic [UPC_W-1:0] L_SUB_BSTP = 6'd14;
  localparam logic [UPC_W-1:0] L_SUB_AB   = 6'd16;
  localparam logic [UPC_W-1:0] L_SUB_ASTP = 6'd17;
  localparam logic [UPC_W-1:0] L_RET_B    = 6'd19;
  localparam logic [UPC_W-1:0] L_BIN      = 6'd20;
  localparam logic [UPC_W-1:0] L_BIN_TWOS = 6'd22;
  localparam logic [UPC_W-1:0] L_BIN_LOOP = 6'd24;
  localparam logic [UPC_W-1:0] L_BIN_HA   = 6'd29;
  localparam logic [UPC_W-1:0] L_BIN_HB   = 6'd30;
  localparam logic [UPC_W-1:0] L_BIN_DA   = 6'd31;
  localparam logic [UPC_W-1:0] L_BIN_RET  = 6'd32;
  localparam logic [UPC_W-1:0] L_EUC_STEP = 6'd6;

  function automatic cw_t mk(input op_t op, input cond_t cond, input logic [UPC_W-1:0] tgt);
    cw_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = tgt;
    return w;
  endfunction

  function automatic logic is_ret(input op_t op);
    return (op == OP_RET_A) || (op == OP_RET_B) || (op == OP_RET_ZERO) || (op == OP_RET_SHL);
  endfunction

  function automatic cw_t gcd3_rom(input logic [UPC_W-1:0] addr);
    cw_t w;
    case (addr)
      // method dispatch
      6'd0:  w = mk(OP_NOP,        C_M1,      L_EUC);
      6'd1:  w = mk(OP_NOP,        C_M2,      L_BIN);
      6'd2:  w = mk(OP_NOP,        C_M0,      L_SUB);
      6'd3:  w = mk(OP_RET_ZERO,   C_NEXT,    '0);
      // euclid: a, b <= b, a mod b
      6'd4:  w = mk(OP_NOP,        C_B_ZERO,  L_RET_A);
      6'd5:  w = mk(OP_DIV_AB,     C_NEXT,    '0);
      6'd6:  w = mk(OP_DIV_STEP,   C_CNT_NZ,  L_EUC_STEP);
      6'd7:  w = mk(OP_EUC_SHIFT,  C_ALWAYS,  L_EUC);
      6'd8:  w = mk(OP_RET_A,      C_NEXT,    '0);
      // subtractive, runs of subtraction folded into one remainder
      6'd9:  w = mk(OP_NOP,        C_A_ZERO,  L_RET_B);
      6'd10: w = mk(OP_NOP,        C_B_ZERO,  L_RET_A);
      6'd11: w = mk(OP_NOP,        C_A_EQ_B,  L_RET_A);
      6'd12: w = mk(OP_NOP,        C_A_GT_B,  L_SUB_AB);
      6'd13: w = mk(OP_DIV_BA,     C_NEXT,    '0);
      6'd14: w = mk(OP_DIV_STEP,   C_CNT_NZ,  L_SUB_BSTP);
      6'd15: w = mk(OP_SUB_B,      C_ALWAYS,  L_SUB_LOOP);
      6'd16: w = mk(OP_DIV_AB,     C_NEXT,    '0);
      6'd17: w = mk(OP_DIV_STEP,   C_CNT_NZ,  L_SUB_ASTP);
      6'd18: w = mk(OP_SUB_A,      C_ALWAYS,  L_SUB_LOOP);
      6'd19: w = mk(OP_RET_B,      C_NEXT,    '0);
      // binary
      6'd20: w = mk(OP_NOP,        C_A_ZERO,  L_RET_B);
      6'd21: w = mk(OP_NOP,        C_B_ZERO,  L_RET_A);
      6'd22: w = mk(OP_NOP,        C_ANY_ODD, L_BIN_LOOP);
      6'd23: w = mk(OP_HALVE_BOTH, C_ALWAYS,  L_BIN_TWOS);
      6'd24: w = mk(OP_NOP,        C_A_EQ_B,  L_BIN_RET);
      6'd25: w = mk(OP_NOP,        C_A_EVEN,  L_BIN_HA);
      6'd26: w = mk(OP_NOP,        C_B_EVEN,  L_BIN_HB);
      6'd27: w = mk(OP_NOP,        C_A_GT_B,  L_BIN_DA);
      6'd28: w = mk(OP_DIFF_B,     C_ALWAYS,  L_BIN_LOOP);
      6'd29: w = mk(OP_HALVE_A,    C_ALWAYS,  L_BIN_LOOP);
      6'd30: w = mk(OP_HALVE_B,    C_ALWAYS,  L_BIN_LOOP);
      6'd31: w = mk(OP_DIFF_A,     C_ALWAYS,  L_BIN_LOOP);
      6'd32: w = mk(OP_RET_SHL,    C_NEXT,    '0);
      default: w = mk(OP_RET_ZERO, C_NEXT,    '0);
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

/* sv/gcd3_if.sv */
// gcd3_if: valid/ready channel interfaces for operands and results
`default_nettype none
interface gcd3_in_if import gcd3_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] first_value;
  logic [FIELD_W-1:0] second_value;

  modport source (output valid, output first_value, output second_value, input ready);
  modport sink   (input valid, input first_value, input second_value, output ready);
endinterface

interface gcd3_out_if import gcd3_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] divisor;

  modport source (output valid, output divisor, input ready);
  modport sink   (input valid, input divisor, output ready);
endinterface
`default_nettype wire

/* sv/gcd_unit_three_methods.sv */
// gcd_unit_three_methods: top level, datapath and configuration register
`default_nettype none
// Greatest common divisor of two unsigned operands, by one of three schemes
// chosen with the method register (0 subtractive, 1 Euclidean, 2 binary;
// code 3 returns zero; reset value 1). Under the three schemes a zero
// operand yields the other one. One operand pair is worked at a time:
// in_ch.ready is low from acceptance until the result is loaded into the
// output register, which can hold a result while the next pair is taken.
// A microinstruction executes per cycle, except while a return waits for a
// stalled output register. Euclidean and subtractive runs are set by the
// shared restoring remainder unit, one quotient bit per cycle, and at most
// about 1.44*WIDTH remainder steps occur. Binary runs are set by the common
// factors of two and the halvings or halved differences, at most about
// 2*WIDTH of them. Every item adds dispatch, final tests and return, and
// the next pair is taken while the unit is idle.
module gcd_unit_three_methods import gcd3_pkg::*; #(
  parameter int WIDTH = DEFAULT_WIDTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  gcd3_in_if.sink                  in_ch,
  gcd3_out_if.source               out_ch,
  input  wire logic                cfg_we,
  input  wire logic [METHOD_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(WIDTH);
  localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(WIDTH - 1);

  logic [METHOD_W-1:0] method_r;
  logic [WIDTH-1:0]    a_r, a_nxt;
  logic [WIDTH-1:0]    b_r, b_nxt;
  logic [WIDTH-1:0]    d_r, d_nxt;
  logic [WIDTH-1:0]    q_r, q_nxt;
  logic [WIDTH-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    twos_r, twos_nxt;
  logic [FIELD_W-1:0]  div_r, div_nxt;
  logic                oval_r, oval_nxt;

  logic                start;
  logic                hold;
  logic                busy;
  flags_t              flags;
  ctl_t                ctl;

  logic [WIDTH+FIELD_W-1:0] first_ext, second_ext;
  logic [WIDTH:0]           rem_sh, rem_sub;
  logic                     rem_ge;
  logic [WIDTH-1:0]         res_val;
  logic [WIDTH+FIELD_W-1:0] res_ext;
  logic [WIDTH-1:0]         a_minus_b, b_minus_a;

  assign start = in_ch.valid && in_ch.ready;
  assign hold  = oval_r && !out_ch.ready;

  assign in_ch.ready    = !busy;
  assign out_ch.valid   = oval_r;
  assign out_ch.divisor = div_r;

  // operands taken modulo 2^WIDTH, result narrowed to the field
  assign first_ext  = {{WIDTH{1'b0}}, in_ch.first_value};
  assign second_ext = {{WIDTH{1'b0}}, in_ch.second_value};

  assign flags.method  = method_r;
  assign flags.a_zero  = (a_r == '0);
  assign flags.b_zero  = (b_r == '0);
  assign flags.a_eq_b  = (a_r == b_r);
  assign flags.a_gt_b  = (a_r > b_r);
  assign flags.any_odd = a_r[0] | b_r[0];
  assign flags.a_even  = !a_r[0];
  assign flags.b_even  = !b_r[0];
  assign flags.cnt_nz  = (cnt_r != '0);

  gcd3_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .hold  (hold),
    .flags (flags),
    .busy  (busy),
    .ctl   (ctl)
  );

  // restoring remainder, one dividend bit per step
  assign rem_sh  = {rem_r, q_r[WIDTH-1]};
  assign rem_sub = rem_sh - {1'b0, d_r};
  assign rem_ge  = (rem_sh >= {1'b0, d_r});

  assign a_minus_b = a_r - b_r;
  assign b_minus_a = b_r - a_r;

  always_comb begin
    case (ctl.op)
      OP_RET_A:   res_val = a_r;
      OP_RET_B:   res_val = b_r;
      OP_RET_SHL: res_val = a_r << twos_r;
      default:    res_val = '0;
    endcase
  end
  assign res_ext = {{FIELD_W{1'b0}}, res_val};

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    d_nxt    = d_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    twos_nxt = twos_r;
    div_nxt  = div_r;
    oval_nxt = out_ch.ready ? 1'b0 : oval_r;
    if (start) begin
      a_nxt    = first_ext[WIDTH-1:0];
      b_nxt    = second_ext[WIDTH-1:0];
      twos_nxt = '0;
    end else if (ctl.exec) begin
      case (ctl.op)
        OP_DIV_AB: begin
          q_nxt   = a_r;
          d_nxt   = b_r;
          rem_nxt = '0;
          cnt_nxt = CNT_INIT;
        end
        OP_DIV_BA: begin
          q_nxt   = b_r;
          d_nxt   = a_r;
          rem_nxt = '0;
          cnt_nxt = CNT_INIT;
        end
        OP_DIV_STEP: begin
          rem_nxt = rem_ge ? rem_sub[WIDTH-1:0] : rem_sh[WIDTH-1:0];
          q_nxt   = q_r << 1;
          cnt_nxt = cnt_r - 1'b1;
        end
        OP_EUC_SHIFT: begin
          a_nxt = b_r;
          b_nxt = rem_r;
        end
        OP_SUB_A: a_nxt = (rem_r == '0) ? b_r : rem_r;
        OP_SUB_B: b_nxt = (rem_r == '0) ? a_r : rem_r;
        OP_HALVE_BOTH: begin
          a_nxt    = a_r >> 1;
          b_nxt    = b_r >> 1;
          twos_nxt = twos_r + 1'b1;
        end
        OP_HALVE_A: a_nxt = a_r >> 1;
        OP_HALVE_B: b_nxt = b_r >> 1;
        OP_DIFF_A:  a_nxt = a_minus_b >> 1;
        OP_DIFF_B:  b_nxt = b_minus_a >> 1;
        OP_RET_A, OP_RET_B, OP_RET_ZERO, OP_RET_SHL: begin
          div_nxt  = res_ext[FIELD_W-1:0];
          oval_nxt = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_r <= METHOD_RESET;
      oval_r   <= 1'b0;
    end else begin
      if (cfg_we) method_r <= cfg_wdata;
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    d_r    <= d_nxt;
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    twos_r <= twos_nxt;
    div_r  <= div_nxt;
  end

endmodule
`default_nettype wire

/* sv/gcd3_seq.sv */
// gcd3_seq: microprogram counter, control store and branch logic
`default_nettype none
module gcd3_seq import gcd3_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   start,
  input  wire logic   hold,
  input  wire flags_t flags,
  output logic        busy,
  output ctl_t        ctl
);

  logic             busy_r, busy_nxt;
  logic [UPC_W-1:0] upc_r, upc_nxt;
  cw_t              cw;
  logic             taken;
  logic             ret;

  assign cw  = gcd3_rom(upc_r);
  assign ret = is_ret(cw.op);

  always_comb begin
    case (cw.cond)
      C_NEXT:    taken = 1'b0;
      C_ALWAYS:  taken = 1'b1;
      C_M0:      taken = (flags.method == METHOD_SUB);
      C_M1:      taken = (flags.method == METHOD_EUC);
      C_M2:      taken = (flags.method == METHOD_BIN);
      C_A_ZERO:  taken = flags.a_zero;
      C_B_ZERO:  taken = flags.b_zero;
      C_A_EQ_B:  taken = flags.a_eq_b;
      C_A_GT_B:  taken = flags.a_gt_b;
      C_ANY_ODD: taken = flags.any_odd;
      C_A_EVEN:  taken = flags.a_even;
      C_B_EVEN:  taken = flags.b_even;
      C_CNT_NZ:  taken = flags.cnt_nz;
      default:   taken = 1'b0;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    upc_nxt  = upc_r;
    if (start) begin
      busy_nxt = 1'b1;
      upc_nxt  = '0;
    end else if (busy_r) begin
      if (ret) begin
        // a return waits until the result register is free
        if (!hold) busy_nxt = 1'b0;
      end else begin
        upc_nxt = taken ? cw.target : upc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      upc_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      upc_r  <= upc_nxt;
    end
  end

  assign busy     = busy_r;
  assign ctl.exec = busy_r && !(ret && hold);
  assign ctl.op   = cw.op;

endmodule
`default_nettype wire

/* sv/gcd3_chk.sv */
// gcd3_chk: port-level assertions for the gcd unit, bound to the top level
`default_nettype none
module gcd3_chk import gcd3_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [FIELD_W-1:0] out_divisor
);

  // a stalled result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_divisor))
    else $error("result changed while stalled");

  // one pair at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again before result");

  // a new result only comes out of a busy unit
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while idle");

  // going idle always leaves a result behind
  a_idle_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_ready) |-> out_valid)
    else $error("unit went idle without a result");

endmodule

bind gcd_unit_three_methods gcd3_chk u_gcd3_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_divisor (out_ch.divisor)
);
`default_nettype wire
